[hdl/itp_pkg.sv]
`timescale 1ns / 1ps

package itp_pkg;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNMATCHED = 2'd2;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } itp_in_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic [1:0] status;
        logic       last_of_run;
        logic       end_of_expression;
    } itp_out_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] sym;
        logic [1:0] status;
    } itp_emit_t;

    typedef struct packed {
        logic valid;
        logic end_of_expression;
    } itp_fin_t;

    typedef struct packed {
        logic emit_ok;
        logic fin_ok;
    } itp_ack_t;

    // Precedence shifted up by one so that the lowest class is zero.
    function automatic logic [2:0] prec_rank(input logic [7:0] ch);
        logic [2:0] r;
        case (ch)
            CH_CARET:          r = 3'd4;
            CH_STAR, CH_SLASH: r = 3'd3;
            CH_PLUS, CH_MINUS: r = 3'd2;
            default:           r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_operand(input logic [7:0] ch);
        return ((ch >= 8'h61) && (ch <= 8'h7A)) ||
               ((ch >= 8'h41) && (ch <= 8'h5A)) ||
               ((ch >= 8'h30) && (ch <= 8'h39));
    endfunction

endpackage

[hdl/itp_stack_mem.sv]
`timescale 1ns / 1ps

module itp_stack_mem #(
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A write to the address being read is forwarded to the read register.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/itp_out_stage.sv]
`timescale 1ns / 1ps

module itp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  itp_pkg::itp_emit_t emit,
    input  itp_pkg::itp_fin_t  fin,
    output itp_pkg::itp_ack_t  ack,
    output logic              res_valid,
    input  logic              res_ready,
    output itp_pkg::itp_out_t res_data
);

    import itp_pkg::*;

    // One result is held back so the final one of a request can be marked.
    logic       pend_valid_reg;
    logic [7:0] pend_sym_reg;
    logic [1:0] pend_status_reg;
    logic       out_valid_reg;
    itp_out_t   out_reg;
    logic       out_free;
    logic       emit_go;
    logic       fin_go;

    assign out_free = !out_valid_reg || res_ready;
    assign ack.emit_ok = !pend_valid_reg || out_free;
    assign ack.fin_ok  = !pend_valid_reg || out_free;
    assign emit_go = emit.valid && ack.emit_ok;
    assign fin_go  = fin.valid && pend_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (emit_go)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (fin_go)
            begin
                pend_valid_reg <= 1'b0;
            end

            if ((emit_go && pend_valid_reg) || fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            pend_sym_reg    <= emit.sym;
            pend_status_reg <= emit.status;
        end
        if ((emit_go && pend_valid_reg) || fin_go)
        begin
            out_reg.out_symbol        <= pend_sym_reg;
            out_reg.status            <= pend_status_reg;
            out_reg.last_of_run       <= fin_go;
            out_reg.end_of_expression <= fin_go && fin.end_of_expression;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule

[hdl/infix_to_postfix_converter.sv]
`timescale 1ns / 1ps

// Infix to postfix converter with an operator stack.
// Requests arrive on the sym channel (sym_valid, sym_ready, sym_data), one
// character each. Results leave on the res channel (res_valid, res_ready,
// res_data); a request causes zero or more results, the final one marked by
// last_of_run, and by end_of_expression too when the request closed the
// expression. Error results carry a status and the offending character.
// A request is taken only while the sequencer is idle. It then passes through
// dispatch, the close state for a closing parenthesis or the operator pop
// state for an operator, then the tail and finish states. The stack has one
// read port, so entries are popped one at a time, and a pop waits while the
// output stage cannot take its result. The next request is accepted once the
// sequencer is back in idle. One result is held back so the final one can be
// marked: a result reaches the output register when the next result of the
// same request is produced, or in the finishing cycle for the final one.
// Reset empties the stack and drops any result in flight; the stack memory
// needs no clearing pass. When the receiver stalls, the sequencer waits on
// its next result and the output register holds its contents.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sym_valid,
    output logic              sym_ready,
    input  itp_pkg::itp_in_t  sym_data,
    output logic              res_valid,
    input  logic              res_ready,
    output itp_pkg::itp_out_t res_data
);

    import itp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_CLOSE    = 6'b000100,
        ST_OPPOP    = 6'b001000,
        ST_TAIL     = 6'b010000,
        ST_FINISH   = 6'b100000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [7:0]      ch_reg;
    logic            last_reg;
    logic            we;
    logic [7:0]      top;
    logic [AW-1:0]   raddr;
    logic [CW-1:0]   raddr_full;
    logic            full;
    logic            empty;
    itp_emit_t       emit;
    itp_fin_t        fin;
    itp_ack_t        ack;

    assign full  = (count_reg == CW'(STACK_DEPTH));
    assign empty = (count_reg == '0);
    assign sym_ready = (state_reg == ST_IDLE);
    assign raddr_full = count_next - CW'(1);
    assign raddr = raddr_full[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        we         = 1'b0;
        emit       = '0;
        fin        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sym_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (is_operand(ch_reg))
                begin
                    emit = '{valid: 1'b1, sym: ch_reg, status: STATUS_OK};
                    if (ack.emit_ok)
                    begin
                        state_next = ST_TAIL;
                    end
                end
                else if (ch_reg == CH_LPAREN)
                begin
                    if (full)
                    begin
                        emit = '{valid: 1'b1, sym: ch_reg, status: STATUS_OVERFLOW};
                        if (ack.emit_ok)
                        begin
                            state_next = ST_TAIL;
                        end
                    end
                    else
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CW'(1);
                        state_next = ST_TAIL;
                    end
                end
                else if (ch_reg == CH_RPAREN)
                begin
                    state_next = ST_CLOSE;
                end
                else
                begin
                    state_next = ST_OPPOP;
                end
            end
            ST_CLOSE:
            begin
                if (empty)
                begin
                    emit = '{valid: 1'b1, sym: CH_RPAREN, status: STATUS_UNMATCHED};
                    if (ack.emit_ok)
                    begin
                        state_next = ST_TAIL;
                    end
                end
                else if (top == CH_LPAREN)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_TAIL;
                end
                else
                begin
                    emit = '{valid: 1'b1, sym: top, status: STATUS_OK};
                    if (ack.emit_ok)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            ST_OPPOP:
            begin
                if (!empty && (prec_rank(ch_reg) <= prec_rank(top)))
                begin
                    emit = '{valid: 1'b1, sym: top, status: STATUS_OK};
                    if (ack.emit_ok)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                else if (full)
                begin
                    emit = '{valid: 1'b1, sym: ch_reg, status: STATUS_OVERFLOW};
                    if (ack.emit_ok)
                    begin
                        state_next = ST_TAIL;
                    end
                end
                else
                begin
                    we         = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (last_reg && !empty)
                begin
                    emit = '{valid: 1'b1, sym: top, status: STATUS_OK};
                    if (ack.emit_ok)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                fin = '{valid: 1'b1, end_of_expression: last_reg};
                if (ack.fin_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sym_valid && sym_ready)
        begin
            ch_reg   <= sym_data.symbol;
            last_reg <= sym_data.last_symbol;
        end
    end

    itp_stack_mem #(
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ch_reg),
        .raddr (raddr),
        .rdata (top)
    );

    itp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .fin       (fin),
        .ack       (ack),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule
